FILE: rtl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg : shared types and constants for the Huffman code builder
// Action codes, datapath operations and the status bundle used between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int NUM_SYMBOLS_DEF   = 256;
  localparam int MAX_CODE_BITS_DEF = 32;
  localparam int WEIGHT_BITS_DEF   = 24;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_BUILD = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOAD,
    OP_CLR_START,
    OP_CLR,
    OP_SCAN_START,
    OP_SCAN,
    OP_NEW,
    OP_LINK_A,
    OP_LINK_B,
    OP_WALK_START,
    OP_WALK_DEC,
    OP_WALK_RD,
    OP_WALK_PAR,
    OP_WALK_WR,
    OP_FINISH,
    OP_READ,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic [1:0] act;
    logic       clr_done;
    logic       scan_done;
    logic       a_found;
    logic       b_found;
    logic       used_eq_n;
    logic       walk_zero;
    logic       walk_skip;
    logic       out_free;
  } hcb_stat_t;

endpackage

FILE: rtl/hcb_ctrl.sv
// ----------------------------------------------------------------------------
// hcb_ctrl : sequencer for the Huffman code builder
// Steps the datapath through load, read and the build passes (leaf clear,
// minimum scan, join, code walk).
// ----------------------------------------------------------------------------
module hcb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  hcb_pkg::hcb_stat_t stat,
  output hcb_pkg::dp_op_t   op
);
  import hcb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CLR, S_SCAN0, S_SCAN, S_DECIDE, S_NEW, S_LINK_A,
    S_LINK_B, S_WALK_START, S_WALK_TEST, S_WALK_RD, S_WALK_PAR, S_WALK_WR,
    S_FINISH, S_OUT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_ACCEPT;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.act == ACT_LOAD) begin
          op         = OP_LOAD;
          state_next = S_IDLE;
        end else if (stat.act == ACT_BUILD) begin
          op         = OP_CLR_START;
          state_next = S_CLR;
        end else if (stat.act == ACT_READ) begin
          op         = OP_READ;
          state_next = S_OUT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CLR: begin
        if (stat.clr_done) state_next = S_SCAN0;
        else               op = OP_CLR;
      end
      S_SCAN0: begin
        op         = OP_SCAN_START;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_DECIDE;
        else                op = OP_SCAN;
      end
      S_DECIDE: begin
        if (stat.b_found || stat.used_eq_n) state_next = S_NEW;
        else                                state_next = S_WALK_START;
      end
      S_NEW: begin
        op         = OP_NEW;
        state_next = stat.a_found ? S_LINK_A : S_WALK_START;
      end
      S_LINK_A: begin
        op         = OP_LINK_A;
        state_next = stat.b_found ? S_LINK_B : S_WALK_START;
      end
      S_LINK_B: begin
        op         = OP_LINK_B;
        state_next = S_SCAN0;
      end
      S_WALK_START: begin
        op         = OP_WALK_START;
        state_next = S_WALK_TEST;
      end
      S_WALK_TEST: begin
        if (stat.walk_zero) begin
          state_next = S_FINISH;
        end else begin
          op         = OP_WALK_DEC;
          state_next = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        op         = OP_WALK_RD;
        state_next = S_WALK_PAR;
      end
      S_WALK_PAR: begin
        if (stat.walk_skip) begin
          state_next = S_WALK_TEST;
        end else begin
          op         = OP_WALK_PAR;
          state_next = S_WALK_WR;
        end
      end
      S_WALK_WR: begin
        op         = OP_WALK_WR;
        state_next = S_WALK_TEST;
      end
      S_FINISH: begin
        op         = OP_FINISH;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          op         = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/hcb_datapath.sv
// ----------------------------------------------------------------------------
// hcb_datapath : node memories, scan trackers and output register
// Holds the tree in memories with a single read port each and carries out one operation of
// the sequencer per cycle.
// ----------------------------------------------------------------------------
module hcb_datapath #(
  parameter int NUM_SYMBOLS   = hcb_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_CODE_BITS = hcb_pkg::MAX_CODE_BITS_DEF,
  parameter int WEIGHT_BITS   = hcb_pkg::WEIGHT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  hcb_pkg::dp_op_t    op,
  output hcb_pkg::hcb_stat_t stat,
  input  logic               cfg_valid,
  input  logic [8:0]         cfg_data,
  input  logic [1:0]         action,
  input  logic [7:0]         symbol_index,
  input  logic [23:0]        weight,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [8:0]         node_count,
  output logic [31:0]        code_bits,
  output logic [5:0]         code_length,
  output logic               too_long
);
  import hcb_pkg::*;

  localparam int NODES  = 2 * NUM_SYMBOLS;
  localparam int NODE_W = $clog2(NODES);
  localparam int CL     = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32;
  localparam logic [23:0] WMASK =
    (WEIGHT_BITS >= 24) ? 24'hFFFFFF : 24'((64'd1 << WEIGHT_BITS) - 64'd1);

  // memories; parent entry top bit marks a parent present
  logic [31:0]       wt_mem   [NODES];
  logic [NODE_W:0]   par_mem  [NODES];
  logic [NODE_W-1:0] left_mem [NODES];
  logic [31:0]       code_mem [NODES];
  logic [5:0]        len_mem  [NODES];
  logic              long_mem [NODES];

  logic [31:0]       wt_q;
  logic [NODE_W:0]   par_q;
  logic [NODE_W-1:0] left_q;
  logic [31:0]       code_q;
  logic [5:0]        len_q;
  logic              long_q;

  // control registers
  logic [8:0]        sym_count;
  logic [NODE_W-1:0] used, built, join_idx, sc_i, cl_i, wi, rd_idx;
  logic              rd_v;
  logic              a_f, b_f;
  logic [NODE_W-1:0] a_i, b_i;
  logic [31:0]       a_w, b_w;
  logic [1:0]        act;
  logic [7:0]        idx;
  logic [23:0]       wt_in;

  logic [NODE_W-1:0] n;
  logic              cand, take_a, take_b, hit;
  logic [32:0]       sum;
  logic [31:0]       sum_sat;
  logic              bit_r;

  // memory port controls
  logic              wt_we, par_we, left_we, cd_we, wp_re, cd_re, left_re;
  logic [NODE_W-1:0] wt_wa, par_wa, cd_wa, wp_ra, cd_ra;
  logic [31:0]       wt_wd, cd_wd;
  logic [NODE_W:0]   par_wd;
  logic [5:0]        ln_wd;
  logic              lg_wd;

  assign n = (32'(sym_count) >= 32'(NUM_SYMBOLS)) ? NODE_W'(NUM_SYMBOLS)
                                                  : NODE_W'(sym_count);

  assign cand   = rd_v && (wt_q != 32'd0) && !par_q[NODE_W];
  assign take_a = cand && (!a_f || (wt_q < a_w));
  assign take_b = cand && !take_a && (!b_f || (wt_q < b_w));

  assign sum     = {1'b0, a_w} + {1'b0, b_w};
  assign sum_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign bit_r   = (left_q != wi);
  assign hit     = (32'(idx) < 32'(built));

  assign stat.act       = act;
  assign stat.clr_done  = (cl_i == n);
  assign stat.scan_done = (sc_i == used) && !rd_v;
  assign stat.a_found   = a_f;
  assign stat.b_found   = b_f;
  assign stat.used_eq_n = (used == n);
  assign stat.walk_zero = (wi == '0);
  assign stat.walk_skip = (wt_q == 32'd0) || !par_q[NODE_W];
  assign stat.out_free  = !out_valid || !out_stall;

  always_comb begin
    wt_we = 1'b0; wt_wa = '0; wt_wd = '0;
    par_we = 1'b0; par_wa = '0; par_wd = '0;
    left_we = 1'b0; left_re = 1'b0;
    cd_we = 1'b0; cd_wa = '0; cd_wd = '0; ln_wd = '0; lg_wd = 1'b0;
    wp_re = 1'b0; wp_ra = '0;
    cd_re = 1'b0; cd_ra = '0;
    unique case (op)
      OP_LOAD: begin
        wt_we = (32'(idx) < 32'(NUM_SYMBOLS));
        wt_wa = NODE_W'(idx);
        wt_wd = 32'(wt_in & WMASK);
      end
      OP_CLR: begin
        par_we = 1'b1; par_wa = cl_i;
        cd_we  = 1'b1; cd_wa  = cl_i;
      end
      OP_SCAN: begin
        wp_re = (sc_i != used);
        wp_ra = sc_i;
      end
      OP_NEW: begin
        wt_we   = 1'b1; wt_wa = used; wt_wd = sum_sat;
        par_we  = 1'b1; par_wa = used;
        left_we = 1'b1;
        cd_we   = 1'b1; cd_wa = used;
      end
      OP_LINK_A: begin
        par_we = 1'b1; par_wa = a_i; par_wd = {1'b1, join_idx};
      end
      OP_LINK_B: begin
        par_we = 1'b1; par_wa = b_i; par_wd = {1'b1, join_idx};
      end
      OP_WALK_RD: begin
        wp_re = 1'b1; wp_ra = wi;
      end
      OP_WALK_PAR: begin
        cd_re = 1'b1; cd_ra = par_q[NODE_W-1:0]; left_re = 1'b1;
      end
      OP_WALK_WR: begin
        cd_we = 1'b1; cd_wa = wi;
        if (long_q || (len_q >= 6'(CL))) begin
          cd_wd = code_q; ln_wd = 6'(CL); lg_wd = 1'b1;
        end else begin
          cd_wd = {code_q[30:0], bit_r}; ln_wd = len_q + 6'd1;
        end
      end
      OP_READ: begin
        cd_re = 1'b1; cd_ra = NODE_W'(idx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[wt_wa] <= wt_wd;
    if (par_we) par_mem[par_wa] <= par_wd;
    if (left_we) left_mem[used] <= a_i;
    if (cd_we) begin
      code_mem[cd_wa] <= cd_wd;
      len_mem[cd_wa]  <= ln_wd;
      long_mem[cd_wa] <= lg_wd;
    end
    if (wp_re) begin
      wt_q  <= wt_mem[wp_ra];
      par_q <= par_mem[wp_ra];
    end
    if (left_re) left_q <= left_mem[cd_ra];
    if (cd_re) begin
      code_q <= code_mem[cd_ra];
      len_q  <= len_mem[cd_ra];
      long_q <= long_mem[cd_ra];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sym_count <= 9'd256;
      used      <= '0;
      built     <= '0;
      rd_v      <= 1'b0;
      a_f       <= 1'b0;
      b_f       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) sym_count <= cfg_data;
      // a new result replaces one taken this cycle
      if (op == OP_OUT) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (op)
        OP_CLR_START: used <= n;
        OP_SCAN_START: begin
          rd_v <= 1'b0; a_f <= 1'b0; b_f <= 1'b0;
        end
        OP_SCAN: begin
          rd_v <= (sc_i != used);
          if (take_a) begin
            a_f <= 1'b1; b_f <= a_f;
          end else if (take_b) begin
            b_f <= 1'b1;
          end
        end
        OP_NEW: used <= used + 1'b1;
        OP_FINISH: built <= n;
        default: ;
      endcase
    end
  end

  // payload and counters
  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        act <= action; idx <= symbol_index; wt_in <= weight;
      end
      OP_CLR_START: cl_i <= '0;
      OP_CLR: cl_i <= cl_i + 1'b1;
      OP_SCAN_START: begin
        sc_i <= '0; a_w <= '0; b_w <= '0;
      end
      OP_SCAN: begin
        if (sc_i != used) begin
          sc_i   <= sc_i + 1'b1;
          rd_idx <= sc_i;
        end
        if (take_a) begin
          a_i <= rd_idx; a_w <= wt_q; b_i <= a_i; b_w <= a_w;
        end else if (take_b) begin
          b_i <= rd_idx; b_w <= wt_q;
        end
      end
      OP_NEW: join_idx <= used;
      OP_WALK_START: wi <= used - 1'b1;
      OP_WALK_DEC: wi <= wi - 1'b1;
      OP_OUT: begin
        node_count <= 9'(used);
        if ((act == ACT_READ) && hit) begin
          code_bits <= code_q; code_length <= len_q; too_long <= long_q;
        end else begin
          code_bits <= '0; code_length <= '0; too_long <= 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/huffman_code_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_builder : builds Huffman codes from per-symbol weights
// Top level joining the sequencer and the node datapath.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall) carries one item: action, symbol_index,
//   weight. A load writes one leaf weight, no result. A build grows the tree
//   over the first symbol_count leaves and returns node_count. A read returns
//   a leaf's code_bits, code_length and too_long flag.
//   Output channel (out_valid / out_stall): one result item per build or read.
//   A stalled result sits in the output register; the next item is still
//   taken, but a later result waits until the register is free.
//   symbol_count is written over cfg_valid / cfg_ready (always high); the user
//   must write it only when idle, which the block itself does not enforce.
// Build cost
//   Leaf clearing over n leaves, then per join a scan over all nodes in use
//   plus the decide and link steps, then the code walk over the nodes below
//   the root (shorter for a skipped node); quadratic in n, set by the single
//   read port of the node memories.
// Reset clears control state only; symbol_count returns to 256 and reads
// before any build give node_count 0 and zero codes.
// ----------------------------------------------------------------------------
module huffman_code_builder #(
  parameter int NUM_SYMBOLS   = hcb_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_CODE_BITS = hcb_pkg::MAX_CODE_BITS_DEF,
  parameter int WEIGHT_BITS   = hcb_pkg::WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  symbol_count,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  symbol_index,
  input  logic [23:0] weight,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  node_count,
  output logic [31:0] code_bits,
  output logic [5:0]  code_length,
  output logic        too_long
);
  import hcb_pkg::*;

  dp_op_t    op;
  hcb_stat_t stat;

  // register writes land straight in the datapath
  assign cfg_ready = 1'b1;

  hcb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  hcb_datapath #(
    .NUM_SYMBOLS   (NUM_SYMBOLS),
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .stat         (stat),
    .cfg_valid    (cfg_valid),
    .cfg_data     (symbol_count),
    .action       (action),
    .symbol_index (symbol_index),
    .weight       (weight),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .node_count   (node_count),
    .code_bits    (code_bits),
    .code_length  (code_length),
    .too_long     (too_long)
  );

endmodule

FILE: test/hcb_checker.sv
// ----------------------------------------------------------------------------
// hcb_checker : scoreboard for the Huffman code builder
// Watches the config, input and output channels. Keeps its own copy of the
// node store, predicts each result item and compares it field by field.
// ----------------------------------------------------------------------------
module hcb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [8:0]  symbol_count,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  symbol_index,
  input  logic [23:0] weight,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [8:0]  node_count,
  input  logic [31:0] code_bits,
  input  logic [5:0]  code_length,
  input  logic        too_long,
  output int          fail_count,
  output int          results_due
);
  import hcb_pkg::*;

  localparam int LEAVES   = NUM_SYMBOLS_DEF;
  localparam int NODES    = 2 * LEAVES;
  localparam int CODE_MAX = (MAX_CODE_BITS_DEF < 32) ? MAX_CODE_BITS_DEF : 32;
  localparam int NO_NODE  = -1;

  typedef struct packed {
    logic [8:0]  nodes;
    logic [31:0] code;
    logic [5:0]  len;
    logic        long_code;
  } code_item_t;

  logic [31:0] node_wt   [NODES];
  int          node_par  [NODES];
  int          node_left [NODES];
  logic [31:0] node_code [NODES];
  logic [5:0]  node_len  [NODES];
  logic        node_long [NODES];
  int          used_nodes;
  int          built_leaves;
  logic [8:0]  leaf_count;
  code_item_t  code_q[$];
  int          errs;

  assign fail_count  = errs;
  assign results_due = code_q.size();

  function automatic int lightest(int span, int skip);
    int best = NO_NODE;
    for (int i = 0; i < span; i++) begin
      if (i == skip || node_wt[i] == 0 || node_par[i] != NO_NODE) continue;
      if (best == NO_NODE || node_wt[i] < node_wt[best]) best = i;
    end
    return best;
  endfunction

  function automatic void add_node(int at, logic [31:0] w, int left);
    node_wt[at]   = w;
    node_par[at]  = NO_NODE;
    node_left[at] = left;
    node_code[at] = '0;
    node_len[at]  = '0;
    node_long[at] = 1'b0;
  endfunction

  function automatic void grow_tree();
    int n;
    int span;
    int a;
    int b;
    int p;
    logic [32:0] sum;
    n = (leaf_count < LEAVES) ? leaf_count : LEAVES;
    span = n;
    for (int i = 0; i < n; i++) begin
      node_par[i]  = NO_NODE;
      node_code[i] = '0;
      node_len[i]  = '0;
      node_long[i] = 1'b0;
    end
    forever begin
      a = lightest(span, NO_NODE);
      if (a == NO_NODE) begin
        // no live symbol: empty root only
        if (span == n) begin
          add_node(span, '0, 0);
          span++;
        end
        break;
      end
      b = lightest(span, a);
      if (b == NO_NODE) begin
        // lone symbol gets a parent so its code is 0, length 1
        if (span == n) begin
          add_node(span, node_wt[a], a);
          node_par[a] = span;
          span++;
        end
        break;
      end
      sum = node_wt[a] + node_wt[b];
      if (sum[32]) sum = 33'h0_FFFF_FFFF;
      add_node(span, sum[31:0], a);
      node_par[a] = span;
      node_par[b] = span;
      span++;
    end
    // code walk from the root down, parents always above children
    for (int i = span - 2; i >= 0; i--) begin
      p = node_par[i];
      if (node_wt[i] == 0 || p < 0 || p >= span) continue;
      if (node_long[p] || node_len[p] >= CODE_MAX) begin
        node_code[i] = node_code[p];
        node_len[i]  = 6'(CODE_MAX);
        node_long[i] = 1'b1;
      end else begin
        node_code[i] = {node_code[p][30:0], (node_left[p] == i) ? 1'b0 : 1'b1};
        node_len[i]  = node_len[p] + 6'd1;
        node_long[i] = 1'b0;
      end
    end
    used_nodes   = span;
    built_leaves = n;
  endfunction

  always @(posedge clk) begin
    code_item_t want;
    code_item_t got;
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        node_wt[i] = '0; node_par[i] = NO_NODE; node_left[i] = 0;
        node_code[i] = '0; node_len[i] = '0; node_long[i] = 1'b0;
      end
      used_nodes   = 0;
      built_leaves = 0;
      leaf_count   = 9'd256;
      code_q.delete();
      errs = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{node_count, code_bits, code_length, too_long};
        if (code_q.size() == 0) begin
          $display("%0t unexpected result item %p", $time, got);
          errs++;
        end else begin
          want = code_q.pop_front();
          if (got.nodes !== want.nodes) begin
            $display("%0t node_count expected %0d got %0d", $time, want.nodes, got.nodes);
            errs++;
          end
          if (got.code !== want.code) begin
            $display("%0t code_bits expected %h got %h", $time, want.code, got.code);
            errs++;
          end
          if (got.len !== want.len) begin
            $display("%0t code_length expected %0d got %0d", $time, want.len, got.len);
            errs++;
          end
          if (got.long_code !== want.long_code) begin
            $display("%0t too_long expected %b got %b", $time, want.long_code,
                     got.long_code);
            errs++;
          end
        end
      end
      if (cfg_valid && cfg_ready) leaf_count = symbol_count;
      if (in_valid && !in_stall) begin
        case (action)
          ACT_LOAD: node_wt[symbol_index] = {8'd0, weight};
          ACT_BUILD: begin
            grow_tree();
            code_q.push_back('{9'(used_nodes), 32'd0, 6'd0, 1'b0});
          end
          ACT_READ: begin
            if (symbol_index < built_leaves)
              code_q.push_back('{9'(used_nodes), node_code[symbol_index],
                                 node_len[symbol_index], node_long[symbol_index]});
            else
              code_q.push_back('{9'(used_nodes), 32'd0, 6'd0, 1'b0});
          end
          default: ;
        endcase
      end
    end
  end
endmodule

FILE: test/tb_huffman_code_builder.sv
// ----------------------------------------------------------------------------
// tb_huffman_code_builder : stimulus and verdict for the code builder
// Directed items cover the empty tree, a lone symbol, absent symbols, stale
// codes and over-long codes; random phases follow with bursty input and a
// stalling receiver. hcb_checker does the comparing.
// ----------------------------------------------------------------------------
module tb_huffman_code_builder;
  import hcb_pkg::*;

  localparam logic [1:0] ACT_NOP  = 2'd3;     // unused code, block ignores it
  localparam int         TIMEOUT  = 3000000;  // cycles

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [8:0]  symbol_count;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  action;
  logic [7:0]  symbol_index;
  logic [23:0] weight;
  logic        out_valid;
  logic        out_stall;
  logic [8:0]  node_count;
  logic [31:0] code_bits;
  logic [5:0]  code_length;
  logic        too_long;
  int          fail_count;
  int          results_due;

  int          cycles;
  int          items_sent;
  int          burst_left;
  int          stall_mode;
  bit          loaded[256];   // leaves given a weight; builds only span these

  huffman_code_builder i_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .symbol_count,
    .in_valid, .in_stall, .action, .symbol_index, .weight,
    .out_valid, .out_stall, .node_count, .code_bits, .code_length, .too_long
  );

  hcb_checker i_chk (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // cycle count and watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > TIMEOUT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: stall pattern switches between free-running, light and heavy
  always @(negedge clk) begin
    if (!rst && $urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // one item on the input channel; called at a falling edge, returns at one
  task automatic send(logic [1:0] act, logic [7:0] idx, logic [23:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid     <= 1'b1;
    action       <= act;
    symbol_index <= idx;
    weight       <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
    items_sent++;
    if (act == ACT_LOAD) loaded[idx] = 1'b1;
  endtask

  // quiet the input and wait for every result, plus load latency slack
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (results_due != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_count(logic [8:0] n);
    drain();
    cfg_valid    <= 1'b1;
    symbol_count <= n;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] rand_weight();
    case ($urandom_range(0, 5))
      0:       return 24'd0;
      1:       return 24'hFFFFFF;
      2:       return 24'($urandom_range(1, 4));
      default: return 24'($urandom);
    endcase
  endfunction

  // give a weight to every leaf below n that never had one
  task automatic fill_leaves(int n);
    for (int i = 0; i < n && i < 256; i++)
      if (!loaded[i]) send(ACT_LOAD, 8'(i), rand_weight());
  endtask

  initial begin
    int n;
    int f0;
    int f1;
    int f2;
    int steps;
    rst = 1'b1; cfg_valid = 1'b0; symbol_count = '0;
    in_valid = 1'b0; action = ACT_LOAD; symbol_index = '0; weight = '0;
    items_sent = 0; burst_left = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reads before any build, then an unused action
    send(ACT_READ, 8'd0, '0);
    send(ACT_READ, 8'd255, '0);
    send(ACT_NOP, 8'd7, 24'h123456);

    // empty tree: no symbols at all
    write_count(9'd0);
    send(ACT_BUILD, '0, '0);
    send(ACT_READ, 8'd0, '0);

    // lone symbol
    write_count(9'd1);
    send(ACT_LOAD, 8'd0, 24'd5);
    send(ACT_BUILD, '0, '0);
    send(ACT_READ, 8'd0, '0);

    // absent symbol, extreme weight, load above the count, stale codes
    write_count(9'd4);
    send(ACT_LOAD, 8'd0, 24'd0);
    send(ACT_LOAD, 8'd1, 24'hFFFFFF);
    send(ACT_LOAD, 8'd2, 24'd1);
    send(ACT_LOAD, 8'd3, 24'd1);
    send(ACT_LOAD, 8'd10, 24'd77);
    send(ACT_BUILD, '0, '0);
    for (int i = 0; i < 5; i++) send(ACT_READ, 8'(i), '0);
    send(ACT_READ, 8'd10, '0);
    send(ACT_LOAD, 8'd1, 24'd2);
    send(ACT_READ, 8'd1, '0);

    // Fibonacci weights make a chain deeper than the code limit
    write_count(9'd36);
    f0 = 1; f1 = 1;
    for (int i = 0; i < 36; i++) begin
      send(ACT_LOAD, 8'(i), 24'(f0));
      f2 = f0 + f1; f0 = f1; f1 = f2;
    end
    send(ACT_BUILD, '0, '0);
    for (int i = 0; i < 4; i++) send(ACT_READ, 8'(i), '0);
    send(ACT_READ, 8'd35, '0);

    // random phases: small trees, each phase opens once all results are in
    while (items_sent < 125) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 24);
      write_count(9'(n));
      fill_leaves(n);
      steps = $urandom_range(6, 20);
      for (int k = 0; k < steps; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: send(ACT_LOAD, 8'($urandom_range(0, (n > 1) ? n + 2 : 3)),
                        rand_weight());
          3:       send(ACT_BUILD, '0, '0);
          9:       send(ACT_NOP, 8'($urandom), 24'($urandom));
          default: send(ACT_READ, ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                  : 8'($urandom_range(0, (n > 0) ? n : 1)), '0);
        endcase
      end
      fill_leaves(n);
      send(ACT_BUILD, '0, '0);
      for (int k = 0; k < 4; k++)
        send(ACT_READ, 8'($urandom_range(0, (n > 0) ? n : 1)), '0);
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
